[hdl/plid_pkg.sv]
// ----------------------------------------------------------------------------
// plid_pkg: shared types and constants for the positional list
// Sizes, status and action codes, cell control and entry conversions.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int CAPACITY   = 128;
  localparam int VALUE_BITS = 32;

  // count holds 0..CAPACITY
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // width that holds both a position and a count
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // read-back OR tree: cells per registered group
  localparam int GROUP = 16;
  localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef logic signed [VALUE_BITS-1:0] entry_t;

  // accepted, valid command broadcast to the chain
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [CMP_W-1:0] pos;
    entry_t           val;
  } list_cmd_t;

  // per-cell controls
  typedef struct packed {
    logic load_new;
    logic load_left;
    logic load_right;
    logic match;
  } cell_ctl_t;

  function automatic entry_t to_entry(input logic signed [31:0] v);
    return VALUE_BITS'(v);
  endfunction

  function automatic logic signed [31:0] from_entry(input entry_t e);
    return 32'(e);
  endfunction

endpackage

[hdl/plid_cell.sv]
// ----------------------------------------------------------------------------
// plid_cell: one list entry
// Loads a new value or its left or right neighbor, and drives its entry onto
// the read-back bus when its position is read.
// ----------------------------------------------------------------------------
module plid_cell import plid_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_val,
  input  entry_t    left_val,
  input  entry_t    right_val,
  output entry_t    entry_val,
  output entry_t    rd_val
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_new) begin
      entry_nxt = new_val;
    end else if (ctl.load_left) begin
      entry_nxt = left_val;
    end else if (ctl.load_right) begin
      entry_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_val = entry_r;
  assign rd_val    = ctl.match ? entry_r : '0;

endmodule

[hdl/plid_chain.sv]
// ----------------------------------------------------------------------------
// plid_chain: the row of entry cells
// Decodes each cell's control from the command, links neighbors, and folds
// the read-back values through a registered OR tree.
// ----------------------------------------------------------------------------
module plid_chain import plid_pkg::*; (
  input  logic      clk,
  input  list_cmd_t cmd,
  output entry_t    rd_data
);

  entry_t    cell_val [CAPACITY];
  entry_t    cell_rd  [CAPACITY];
  cell_ctl_t cell_ctl [CAPACITY];
  entry_t    grp_r    [NGRP];
  entry_t    grp_nxt  [NGRP];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_v;
    entry_t right_v;
    logic   at_pos;
    logic   past_pos;
    logic   from_pos;

    // past_pos: cell lies after the addressed one; from_pos: at or after it
    assign at_pos   = (cmd.pos == CMP_W'(i + 1));
    assign past_pos = (cmd.pos <= CMP_W'(i));
    assign from_pos = (cmd.pos <= CMP_W'(i + 1));

    assign cell_ctl[i].load_new   = cmd.ins & at_pos;
    assign cell_ctl[i].load_left  = cmd.ins & past_pos;
    assign cell_ctl[i].load_right = cmd.del & from_pos;
    assign cell_ctl[i].match      = cmd.rd & at_pos;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end

    plid_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .new_val   (cmd.val),
      .left_val  (left_v),
      .right_val (right_v),
      .entry_val (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_data = rd_data | grp_r[g];
    end
  end

endmodule

[hdl/positional_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top: ordered list with insert, delete, read
// Count, status check, command broadcast and result register.
// ----------------------------------------------------------------------------
// Each item is one action on a list of up to CAPACITY entries held in a row
// of cells, one register per entry. An accepted insert or delete shifts every
// later entry by one place in the cycle of acceptance. A read masks the
// addressed cell onto a two-level OR tree: one registered level of groups of
// sixteen cells, then the final OR into the result register. The result item
// is offered once the group registers and then the result register have been
// loaded, and the next item is taken once the result has been delivered. The
// entry storage has no reset; only the count and the handshake state are
// cleared.
module positional_list_insert_delete_top import plid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [7:0]         out_list_length
);

  typedef enum logic {
    S_IDLE,
    S_SUM
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  status_t            status_nxt;
  status_t            status_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_value_r;
  logic [7:0]         out_len_r;

  logic               accept;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W:0]     cnt_p1;
  list_cmd_t          cmd;
  entry_t             rd_data;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign cnt_p1   = (CMP_W + 1)'(cnt_ext) + (CMP_W + 1)'(1);

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    cmd.rd     = 1'b0;
    cmd.pos    = pos_ext;
    cmd.val    = to_entry(in_item_value);
    case (in_action)
      ACT_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (pos_ext == '0 || (CMP_W + 1)'(pos_ext) > cnt_p1) begin
          status_nxt = ST_BADPOS;
        end else begin
          cmd.ins   = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_DELETE, ACT_READ: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status_nxt = ST_BADPOS;
        end else if (in_action == ACT_DELETE) begin
          cmd.del   = accept;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          cmd.rd = accept;
        end
      end
      default: begin
        status_nxt = ST_BADPOS;
      end
    endcase
  end

  plid_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            count_r   <= count_nxt;
            status_r  <= status_nxt;
            out_len_r <= 8'(count_nxt);
            state_r   <= S_SUM;
          end
        end
        S_SUM: begin
          // group level was captured at acceptance; finish the OR
          out_status_r <= status_r;
          out_value_r  <= from_entry(rd_data);
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_list_length = out_len_r;

endmodule
